// ----- rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted table binary search core.
// Used by every module of the block and by its checker; no dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 128;
    localparam int IDX_W               = 7;
    localparam int DATA_W              = 32;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         entry_address;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
        logic [IDX_W-1:0]         range_low;
        logic [IDX_W-1:0]         range_high;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } t_out_item;

    // Engine status toward the top level
    typedef struct packed {
        logic idle;   // ready for a new item
        logic done;   // result handed over this cycle
    } t_eng_stat;

endpackage

// ----- rtl/stbs_table_ram.sv -----
// Table storage: one write port, one read port, registered read data.
// Depends on stbs_pkg for the entry width.
`timescale 1ns / 1ps

module stbs_table_ram #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [stbs_pkg::DATA_W-1:0] o_rdata
);

    logic signed [stbs_pkg::DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [stbs_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/stbs_search_engine.sv -----
// Search sequencer: takes load and search items, drives the table ports,
// narrows the index range one probe per cycle. Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_search_engine #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  stbs_pkg::t_in_item                 i_item,
    input  logic                               i_res_free,
    output stbs_pkg::t_eng_stat                o_stat,
    output stbs_pkg::t_out_item                o_res,
    output logic                               o_ram_we,
    output logic [AW-1:0]                      o_ram_waddr,
    output logic signed [stbs_pkg::DATA_W-1:0] o_ram_wdata,
    output logic [AW-1:0]                      o_ram_raddr,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_ram_rdata
);

    localparam int IW = stbs_pkg::IDX_W;
    localparam int CW = (AW > IW) ? AW : IW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [IW-1:0]                      r_lo, n_lo;
    logic [IW-1:0]                      r_hi, n_hi;
    logic [IW-1:0]                      r_mid;
    logic signed [stbs_pkg::DATA_W-1:0] r_key;
    stbs_pkg::t_out_item                r_res, n_res;

    logic          w_search;
    logic [IW-1:0] w_in_hi;
    logic          w_in_empty;
    logic [IW:0]   w_sum;
    logic [IW-1:0] w_rd_mid;
    logic [CW-1:0] w_raddr_ext;
    logic [CW-1:0] w_waddr_ext;
    logic          w_lt;
    logic          w_gt;

    assign w_search = i_start && (i_item.command == stbs_pkg::CMD_SEARCH);

    // clamp the high bound to the last table entry
    always_comb begin
        if (CW'(i_item.range_high) > CW'(TABLE_DEPTH - 1)) begin
            w_in_hi = IW'(TABLE_DEPTH - 1);
        end else begin
            w_in_hi = i_item.range_high;
        end
    end
    assign w_in_empty = i_item.range_low > w_in_hi;

    assign w_lt = r_key < i_ram_rdata;
    assign w_gt = r_key > i_ram_rdata;

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                n_lo = i_item.range_low;
                n_hi = w_in_hi;
                if (w_search) begin
                    n_res = '0;
                    n_state = w_in_empty ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!w_lt && !w_gt) begin
                    n_res.found       = 1'b1;
                    n_res.match_index = r_mid;
                    n_state           = ST_DONE;
                end else if (w_lt) begin
                    // range empties once the probe sits on the low bound
                    if (r_mid == r_lo) begin
                        n_state = ST_DONE;
                    end else begin
                        n_hi = r_mid - IW'(1);
                    end
                end else begin
                    if (r_mid == r_hi) begin
                        n_state = ST_DONE;
                    end else begin
                        n_lo = r_mid + IW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // next probe address comes straight from the narrowed bounds
    assign w_sum       = {1'b0, n_lo} + {1'b0, n_hi};
    assign w_rd_mid    = w_sum[IW:1];
    assign w_raddr_ext = CW'(w_rd_mid);
    assign o_ram_raddr = w_raddr_ext[AW-1:0];

    assign w_waddr_ext = CW'(i_item.entry_address);
    assign o_ram_we    = i_start && (i_item.command == stbs_pkg::CMD_LOAD)
                         && (w_waddr_ext <= CW'(TABLE_DEPTH - 1));
    assign o_ram_waddr = w_waddr_ext[AW-1:0];
    assign o_ram_wdata = i_item.entry_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= w_rd_mid;
        r_res <= n_res;
        if (w_search) begin
            r_key <= i_item.search_key;
        end
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE) && i_res_free;
    assign o_res       = r_res;

endmodule

// ----- rtl/sorted_table_binary_search_core.sv -----
// Top level of the sorted table binary search core: handshakes and result
// register around the search engine and table memory. Depends on stbs_pkg.
`timescale 1ns / 1ps

// Sorted table binary search core. Software loads the table one entry per
// item (command = load) and keeps it sorted ascending; a load returns nothing,
// and a load beyond the table is dropped. A search item carries a signed key
// and an inclusive index range; the high bound is clamped to the last entry.
// The block probes the midpoint, rounded down, narrows the range and returns
// found plus the match index (0 when not found). A search occupies the engine
// from accept through its probes (at most floor(log2(range size)) + 1, so 8
// for a 128-entry table) to the hand-over of the result to the output
// register; the hand-over waits while that register is full, and an empty
// range goes from accept to hand-over without a probe. The probe rate is set
// by the single table read port, read once per probe with registered read
// data. Items are taken one at a time: loads and searches never overlap, so a
// table write never races a probe read. The output register lets the next
// item enter while the previous result still waits for the consumer. Entries
// must be loaded before a search can probe them; the table has no reset.

module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stbs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stbs_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);

    stbs_pkg::t_eng_stat                w_stat;
    stbs_pkg::t_out_item                w_res;
    logic                               w_start;
    logic                               w_res_free;
    logic                               w_ram_we;
    logic [AW-1:0]                      w_ram_waddr;
    logic signed [stbs_pkg::DATA_W-1:0] w_ram_wdata;
    logic [AW-1:0]                      w_ram_raddr;
    logic signed [stbs_pkg::DATA_W-1:0] w_ram_rdata;

    logic                r_out_valid;
    stbs_pkg::t_out_item r_out_item;

    // accept only while the engine sits idle
    assign o_in_ready = w_stat.idle;
    assign w_start    = i_in_valid && o_in_ready;

    // result slot is free when empty or drained this cycle
    assign w_res_free = !r_out_valid || i_out_ready;

    stbs_search_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (i_in_item),
        .i_res_free  (w_res_free),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    stbs_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // output register: load on hand-over, drop on consumer accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/stbs_checker.sv -----
// Port-level checks for the sorted table binary search core, with the bind
// that attaches them. Depends on stbs_pkg and the top level's ports.
`timescale 1ns / 1ps

module stbs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input stbs_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input stbs_pkg::t_out_item o_out_item
);

    // hold a result until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before accept");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |-> o_out_item.match_index == '0)
        else $error("not-found result carries nonzero index");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_item.command == stbs_pkg::CMD_LOAD)
        |=> o_in_ready)
        else $error("load item stalled the input");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_item.command == stbs_pkg::CMD_SEARCH)
        |=> !o_in_ready)
        else $error("search item did not occupy the engine");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("engine not idle after result hand-over");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- tb/sorted_table_binary_search_core_checker.sv -----
// Scoreboard for the sorted table binary search core: mirrors the table,
// predicts every search result and compares it with the output channel.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module sorted_table_binary_search_core_checker
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_hits,
    output int        o_misses
);

    logic signed [DATA_W-1:0] entry_mirror [TABLE_DEPTH];
    t_out_item                lookup_q [$];

    // Walk the probe sequence over the mirrored table.
    function automatic t_out_item lookup_key(input t_in_item it);
        logic signed [DATA_W-1:0] key;
        int                       lo;
        int                       hi;
        int                       mid;
        bit                       hit;
        t_out_item                res;
        key = it.search_key;
        lo  = int'(it.range_low);
        hi  = int'(it.range_high);
        hit = 1'b0;
        res = '0;
        if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
        while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (key < entry_mirror[mid]) begin
                hi = mid - 1;
            end else if (key > entry_mirror[mid]) begin
                lo = mid + 1;
            end else begin
                hit             = 1'b1;
                res.found       = 1'b1;
                res.match_index = mid[IDX_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            // Start from an all-zero table and an empty queue.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                entry_mirror[i] = '0;
            end
            lookup_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_hits       <= 0;
            o_misses     <= 0;
        end else begin
            // Results first: a result can never belong to an item taken at this edge.
            if (i_out_valid && i_out_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("result with no search pending: found %0d match_index %0d",
                           i_out_item.found, i_out_item.match_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = lookup_q.pop_front();
                    if (i_out_item.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found,
                               i_out_item.found);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_out_item.match_index !== want.match_index) begin
                        $error("match_index: expected %0d, actual %0d",
                               want.match_index, i_out_item.match_index);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.command == CMD_LOAD) begin
                    if (int'(i_in_item.entry_address) < TABLE_DEPTH)
                        entry_mirror[i_in_item.entry_address] = i_in_item.entry_value;
                end else begin
                    want = lookup_key(i_in_item);
                    lookup_q.push_back(want);
                    if (want.found) o_hits <= o_hits + 1;
                    else            o_misses <= o_misses + 1;
                end
            end
            o_pending <= lookup_q.size();
        end
    end

endmodule

// ----- tb/sorted_table_binary_search_core_tb.sv -----
// Testbench top for the sorted table binary search core: clock, reset,
// load and search stimulus, output flow control and the verdict.
// Depends on stbs_pkg, the core and sorted_table_binary_search_core_checker.
`timescale 1ns / 1ps

module sorted_table_binary_search_core_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEFAULT;
    localparam int ITEM_TARGET  = 1800;
    localparam int REFILL_EVERY = 600;     // items per rebuild period, rebuild loads included
    localparam int HOLD_CYCLES  = 300;     // long output hold-off
    localparam int DRAIN_CYCLES = 16;      // idle margin after the last result is taken
    localparam int CYCLE_LIMIT  = 400000;

    localparam longint VAL_MIN = -64'sd2147483648;
    localparam longint VAL_MAX = 64'sd2147483647;

    // Table rebuild styles
    localparam int FILL_DENSE     = 0;   // narrow values, many duplicates
    localparam int FILL_SPREAD    = 1;   // moderate gaps around zero
    localparam int FILL_FULL_SPAN = 2;   // minimum to maximum of the value range

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending;
    int hits;
    int misses;

    t_flow flow_mode;
    logic  hold_req;
    logic  hold_taken = 1'b0;
    int    hold_left  = 0;
    int    cycle_cnt  = 0;

    int n_items;
    int n_loads;
    int n_searches;

    // Stimulus-side copy of the table, used to pick keys and keep it sorted
    logic signed [DATA_W-1:0] shadow [TABLE_DEPTH];

    always #2 clk = ~clk;

    sorted_table_binary_search_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    sorted_table_binary_search_core_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_hits      (hits),
        .o_misses    (misses)
    );

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit src_gap();
        if (flow_mode == FLOW_SRC_GAPS) return $urandom_range(99) < 65;
        if (flow_mode == FLOW_BOTH)     return $urandom_range(99) < 36;
        return 1'b0;
    endfunction

    function automatic bit sink_stall();
        if (flow_mode == FLOW_SINK_STALLS) return $urandom_range(99) < 65;
        if (flow_mode == FLOW_BOTH)        return $urandom_range(99) < 36;
        return 1'b0;
    endfunction

    // Output side. The long hold-off is counted here, while the sender keeps
    // offering items, so the engine and the result register both fill up.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES - 1;
            hold_taken <= 1'b1;
        end else begin
            out_ready <= !sink_stall();
        end
    end

    // Offer one item and hold it until the edge that accepts it. Valid is
    // lowered only when a gap is inserted, so back-to-back items keep it high.
    task automatic push_item(input t_in_item it);
        if (src_gap()) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (src_gap());
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        n_items++;
    endtask

    task automatic send_load(input int addr, input longint value);
        t_in_item it;
        it               = '0;
        it.command       = CMD_LOAD;
        it.entry_address = addr[IDX_W-1:0];
        it.entry_value   = value[DATA_W-1:0];
        // Search fields are unused by a load; fill them with noise.
        it.search_key    = $urandom;
        it.range_low     = $urandom_range(TABLE_DEPTH - 1);
        it.range_high    = $urandom_range(TABLE_DEPTH - 1);
        shadow[addr]     = value[DATA_W-1:0];
        n_loads++;
        push_item(it);
    endtask

    task automatic send_search(input longint key, input int lo, input int hi);
        t_in_item it;
        it               = '0;
        it.command       = CMD_SEARCH;
        it.entry_address = $urandom_range(TABLE_DEPTH - 1);
        it.entry_value   = $urandom;
        it.search_key    = key[DATA_W-1:0];
        it.range_low     = lo[IDX_W-1:0];
        it.range_high    = hi[IDX_W-1:0];
        n_searches++;
        push_item(it);
    endtask

    // Rewrite the whole table in ascending order.
    task automatic refill_table(input int style);
        longint v;
        int     step_max;
        case (style)
            FILL_DENSE: begin
                v        = longint'($urandom_range(40)) - 20;
                step_max = 1;
            end
            FILL_SPREAD: begin
                v        = longint'($urandom_range(2000000)) - 1000000;
                step_max = 5000;
            end
            default: begin
                v        = VAL_MIN;
                step_max = 1 << 26;
            end
        endcase
        for (int a = 0; a < TABLE_DEPTH; a++) begin
            if (style == FILL_FULL_SPAN && a == TABLE_DEPTH - 1) v = VAL_MAX;
            if (v > VAL_MAX) v = VAL_MAX;
            send_load(a, v);
            v = v + longint'($urandom_range(step_max));
        end
    endtask

    // Overwrite one entry with a value between its neighbors.
    task automatic sorted_load();
        int     a;
        longint lo_v;
        longint hi_v;
        longint span;
        longint v;
        a    = $urandom_range(TABLE_DEPTH - 1);
        lo_v = (a == 0) ? VAL_MIN : longint'(shadow[a - 1]);
        hi_v = (a == TABLE_DEPTH - 1) ? VAL_MAX : longint'(shadow[a + 1]);
        if (hi_v < lo_v) begin
            v = lo_v;
        end else begin
            span = hi_v - lo_v + 1;
            v    = lo_v + longint'($urandom % span);
        end
        send_load(a, v);
    endtask

    task automatic random_search();
        int     lo;
        int     hi;
        int     pick;
        int     r;
        longint key;
        r = $urandom_range(99);
        if (r < 55) begin
            lo = $urandom_range(TABLE_DEPTH - 1);
            hi = $urandom_range(TABLE_DEPTH - 1);
            if (lo > hi) begin
                pick = lo;
                lo   = hi;
                hi   = pick;
            end
        end else if (r < 70) begin
            lo = 0;
            hi = TABLE_DEPTH - 1;
        end else if (r < 80) begin
            lo = $urandom_range(TABLE_DEPTH - 1);
            hi = lo;
        end else if (r < 90) begin
            // empty range
            hi = $urandom_range(TABLE_DEPTH - 2);
            lo = $urandom_range(TABLE_DEPTH - 1, hi + 1);
        end else begin
            lo = $urandom_range(TABLE_DEPTH - 1);
            hi = lo + $urandom_range(7);
            if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
        end
        pick = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(TABLE_DEPTH - 1);
        r    = $urandom_range(99);
        if (r < 50) begin
            key = shadow[pick];
        end else if (r < 70) begin
            key = $urandom_range(1) ? shadow[pick] + 1 : shadow[pick] - 1;
        end else if (r < 85) begin
            key = $urandom;
        end else begin
            case ($urandom_range(3))
                0:       key = VAL_MIN;
                1:       key = VAL_MAX;
                2:       key = 0;
                default: key = -1;
            endcase
        end
        send_search(key, lo, hi);
    endtask

    initial begin
        int refills;
        int n_directed;
        int r;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        flow_mode  <= FLOW_FREE;
        hold_req   <= 1'b0;
        n_items    = 0;
        n_loads    = 0;
        n_searches = 0;
        refills    = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a few entries at both ends of the table, value extremes,
        // hits at the edges, a miss between entries, empty ranges, duplicates and
        // an unsorted table. Every probed entry is loaded first.
        send_load(0, VAL_MIN);
        send_load(1, -1);
        send_load(2, 0);
        send_load(3, VAL_MAX);
        send_load(126, 5);
        send_load(127, VAL_MAX);
        send_search(VAL_MIN, 0, 3);
        send_search(VAL_MAX, 0, 3);
        send_search(1, 0, 3);
        send_search(0, 2, 2);
        send_search(5, 126, 127);
        send_search(VAL_MAX, 127, 127);
        send_search(VAL_MIN, 126, 127);
        send_search(VAL_MAX, 127, 0);
        send_search(0, 1, 0);
        // equal neighbors: the probe sequence decides which one is reported
        send_load(2, -1);
        send_search(-1, 0, 3);
        send_search(-1, 2, 3);
        // break the order: the full-range search misses, the one-entry range hits
        send_load(0, 100);
        send_search(100, 0, 3);
        send_search(100, 0, 0);
        n_directed = n_items;

        // Random part: full tables rebuilt now and then, mostly searches with
        // keys taken from the table, order-keeping updates and a little noise.
        while (n_items < ITEM_TARGET) begin
            flow_mode <= t_flow'(((n_items * 8) / ITEM_TARGET) % 4);
            if (n_items - n_directed >= refills * REFILL_EVERY) begin
                refill_table(refills % 3);
                refills++;
            end else begin
                if (!hold_req && n_items >= ITEM_TARGET / 2 + 20) hold_req <= 1'b1;
                r = $urandom_range(99);
                if (r < 72)      random_search();
                else if (r < 95) sorted_load();
                else             send_load($urandom_range(TABLE_DEPTH - 1), $signed($urandom));
            end
        end
        in_valid <= 1'b0;

        // Let the checker see the last item, then drain.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d searches (%0d hits, %0d misses), %0d table rebuilds",
                 n_loads, n_searches, hits, misses, refills);
        $display("flow phases: free, sender gaps, receiver stalls, both; one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (pending != 0) $error("%0d search results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
